/* rtl/lru_assoc_context_cache_unit_assert.svh */
// assertion macros shared by the context cache rtl
`ifndef LRU_ASSOC_CONTEXT_CACHE_UNIT_ASSERT_SVH
`define LRU_ASSOC_CONTEXT_CACHE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LACC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define LACC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lacc_pkg.sv */
// shared types and constants of the context cache
package lacc_pkg;

	localparam int ENTRIES_DEF   = 128;
	localparam int KEY_BITS_DEF  = 64;
	localparam int MASK_BITS_DEF = 18;
	localparam int CLIP_BIT      = 7;
	localparam int SLOT_W        = 7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_UPDATE,
		ST_RESP
	} lacc_state_t;

	typedef struct packed {
		logic capture;
		logic scan;
		logic update;
		logic respond;
	} lacc_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_busy;
	} lacc_stat_t;

endpackage

/* rtl/lacc_ctrl.sv */
// sequencer for one lookup: capture, sweep, update, respond
module lacc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lacc_pkg::lacc_stat_t stat,
	output lacc_pkg::lacc_cmd_t  cmd
);
	import lacc_pkg::*;

	lacc_state_t state_q;
	lacc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_last) state_d = ST_LAST;
			end
			ST_LAST: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!stat.out_busy) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_LAST: begin
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			ST_RESP: begin
				cmd.respond = !stat.out_busy;
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/lacc_dp.sv */
// tag memory, recency ring, search registers and output register
module lacc_dp #(
	parameter int ENTRIES   = lacc_pkg::ENTRIES_DEF,
	parameter int KEY_BITS  = lacc_pkg::KEY_BITS_DEF,
	parameter int MASK_BITS = lacc_pkg::MASK_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lacc_pkg::lacc_cmd_t         cmd,
	output lacc_pkg::lacc_stat_t        stat,
	input  logic [KEY_BITS-1:0]         value_key,
	input  logic [MASK_BITS-1:0]        attr_mask,
	input  logic                        clip_present,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output logic [lacc_pkg::SLOT_W-1:0] slot,
	output logic                        replaced
);
	import lacc_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int TAG_W = KEY_BITS + MASK_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

	// request, normalized at capture
	logic [MASK_BITS-1:0] clip_clr;
	logic [MASK_BITS-1:0] mask_n;
	logic [KEY_BITS-1:0]  req_key_q;
	logic [MASK_BITS-1:0] req_mask_q;

	// storage
	logic [TAG_W-1:0] tag_mem [ENTRIES];
	logic [IDX_W-1:0] rank_q  [ENTRIES];
	logic [CNT_W-1:0] count_q;

	// sweep pipeline
	logic [IDX_W-1:0] addr_q;
	logic [TAG_W-1:0] rd_tag_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] rank_s1;
	logic             vld_s1;
	logic             rd_vld_s1;
	logic             match;

	// search results
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [IDX_W-1:0] hit_rank_q;
	logic [IDX_W-1:0] lru_idx_q;
	logic [IDX_W-1:0] lru_rank_q;

	// update decision
	logic             full;
	logic [IDX_W-1:0] sel_idx;
	logic [IDX_W-1:0] old_rank;
	logic [CNT_W-1:0] count_new;
	logic             repl_d;
	logic [IDX_W+SLOT_W-1:0] slot_ext;

	// result and output register
	logic              res_hit_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_repl_q;
	logic              out_valid_q;
	logic              out_hit_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_repl_q;

	always_comb begin
		clip_clr           = '0;
		clip_clr[CLIP_BIT] = ~clip_present;
		mask_n             = attr_mask & ~clip_clr;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_key_q  <= value_key;
			req_mask_q <= mask_n;
		end
	end

	// tag memory: one read port for the sweep, one write on update after a miss
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_tag_s1 <= tag_mem[addr_q];
		end
		if (cmd.update && !hit_q) begin
			tag_mem[sel_idx] <= {req_key_q, req_mask_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			idx_s1  <= addr_q;
			rank_s1 <= rank_q[0];
			vld_s1  <= {1'b0, addr_q} < count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			if (cmd.capture) begin
				addr_q <= '0;
			end else if (cmd.scan) begin
				addr_q <= addr_q + IDX_W'(1);
			end
		end
	end

	assign match = rd_vld_s1 && vld_s1 && (rd_tag_s1 == {req_key_q, req_mask_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			hit_rank_q <= '0;
			lru_idx_q  <= '0;
			lru_rank_q <= '0;
		end else if (cmd.capture) begin
			hit_q      <= 1'b0;
			lru_idx_q  <= '0;
			lru_rank_q <= '0;
		end else if (rd_vld_s1 && vld_s1) begin
			if (match && !hit_q) begin
				hit_q      <= 1'b1;
				hit_idx_q  <= idx_s1;
				hit_rank_q <= rank_s1;
			end
			if (rank_s1 >= lru_rank_q) begin
				lru_idx_q  <= idx_s1;
				lru_rank_q <= rank_s1;
			end
		end
	end

	always_comb begin
		full      = count_q == FULL_CNT;
		sel_idx   = hit_idx_q;
		old_rank  = hit_rank_q;
		count_new = count_q;
		repl_d    = 1'b0;
		if (!hit_q) begin
			if (!full) begin
				sel_idx   = count_q[IDX_W-1:0];
				old_rank  = count_q[IDX_W-1:0];
				count_new = count_q + CNT_W'(1);
			end else begin
				sel_idx  = lru_idx_q;
				old_rank = lru_rank_q;
				repl_d   = 1'b1;
			end
		end
		slot_ext = {{SLOT_W{1'b0}}, sel_idx};
	end

	// recency ring: rotates once per sweep step, per-lane age update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
			count_q <= '0;
		end else if (cmd.scan) begin
			for (int i = 0; i < ENTRIES - 1; i++) begin
				rank_q[i] <= rank_q[i+1];
			end
			rank_q[ENTRIES-1] <= rank_q[0];
		end else if (cmd.update) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (IDX_W'(i) == sel_idx) begin
					rank_q[i] <= '0;
				end else if ((CNT_W'(i) < count_new) && (rank_q[i] < old_rank)) begin
					rank_q[i] <= rank_q[i] + IDX_W'(1);
				end
			end
			count_q <= count_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_hit_q  <= hit_q;
			res_slot_q <= slot_ext[SLOT_W-1:0];
			res_repl_q <= repl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.respond) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			out_hit_q  <= res_hit_q;
			out_slot_q <= res_slot_q;
			out_repl_q <= res_repl_q;
		end
	end

	assign stat.scan_last = addr_q == LAST_IDX;
	assign stat.out_busy  = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign hit       = out_hit_q;
	assign slot      = out_slot_q;
	assign replaced  = out_repl_q;

endmodule

/* rtl/lru_assoc_context_cache_unit.sv */
// top level of the fully associative lru context cache
// a lookup runs capture, sweep, last compare, update and respond; respond waits while the output is held
// a new lookup is taken only after the last one has responded; the pace is set by the sweep of the tag memory
//   through its single read port, one entry per cycle
// reset: valid count and all recency ranks cleared at once, no clearing pass;
//   the tag memory is not reset and is only compared below the valid count
module lru_assoc_context_cache_unit #(
	parameter int ENTRIES   = lacc_pkg::ENTRIES_DEF,
	parameter int KEY_BITS  = lacc_pkg::KEY_BITS_DEF,
	parameter int MASK_BITS = lacc_pkg::MASK_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [KEY_BITS-1:0]         value_key,
	input  logic [MASK_BITS-1:0]        attr_mask,
	input  logic                        clip_present,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output logic [lacc_pkg::SLOT_W-1:0] slot,
	output logic                        replaced
);
	import lacc_pkg::*;

	`include "lru_assoc_context_cache_unit_assert.svh"

	// command and status between sequencer and datapath
	lacc_cmd_t  cmd;
	lacc_stat_t stat;

	// sequencer: idle, sweep all entries, last compare, update, respond
	lacc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: tag memory swept by index, recency ranks in a rotating ring so
	// the rank of the entry under compare sits at a fixed tap
	lacc_dp #(
		.ENTRIES   (ENTRIES),
		.KEY_BITS  (KEY_BITS),
		.MASK_BITS (MASK_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.value_key    (value_key),
		.attr_mask    (attr_mask),
		.clip_present (clip_present),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.slot         (slot),
		.replaced     (replaced)
	);

	// one lookup in flight: after an input beat the request port closes
	`LACC_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, in_valid && in_ready, !in_ready, "input accepted while a lookup is in flight")
	// a result never overwrites one that is still held
	`LACC_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.respond, !(out_valid && !out_ready), "output register overwritten while held")
	// the sweep ends after the last entry
	`LACC_ASSERT_NEXT(a_sweep_ends, clk, arst_n, cmd.scan && stat.scan_last, !cmd.scan, "sweep ran past the last entry")

endmodule
